>>> design/lppd_pkg.sv
// Shared types and constants for the length-prefixed packet deframer.
// No dependencies; imported by the parser, the output stage and the top level.
`timescale 1ns / 1ps

package lppd_pkg;

  // Lead bytes and header sizes
  localparam logic [7:0]  LEAD_SHORT = 8'hC1;
  localparam logic [7:0]  LEAD_LONG  = 8'hC2;
  localparam logic [15:0] HDR_SHORT  = 16'd3;
  localparam logic [15:0] HDR_LONG   = 16'd4;

  // Parser phases
  localparam logic [2:0] PH_HUNT      = 3'd0;
  localparam logic [2:0] PH_LEN_SHORT = 3'd1;
  localparam logic [2:0] PH_LEN_HIGH  = 3'd2;
  localparam logic [2:0] PH_LEN_LOW   = 3'd3;
  localparam logic [2:0] PH_BODY      = 3'd4;

  // Error codes
  localparam logic [1:0] ERR_NONE      = 2'd0;
  localparam logic [1:0] ERR_LEAD      = 2'd1;
  localparam logic [1:0] ERR_TOO_SHORT = 2'd2;
  localparam logic [1:0] ERR_TOO_LONG  = 2'd3;

  // One result item per input byte
  typedef struct packed {
    logic [7:0]  byte_out;
    logic        in_frame;
    logic        first_of_frame;
    logic        last_of_frame;
    logic        is_head_code;
    logic [15:0] frame_length;
    logic [1:0]  error_code;
  } lppd_result_t;

endpackage

>>> design/lppd_parser.sv
// Frame parser: phase state, length capture and per-byte marks.
// Depends on lppd_pkg for phase codes, error codes and the result type.
`timescale 1ns / 1ps

module lppd_parser (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  accept,
  input  logic [7:0]            data_byte,
  input  logic [15:0]           max_frame_size,
  output lppd_pkg::lppd_result_t result
);
  import lppd_pkg::*;

  logic [2:0]  phase;
  logic [2:0]  phase_next;
  logic        two_byte_length;
  logic        two_byte_length_next;
  logic [15:0] length_value;
  logic [15:0] length_value_next;
  logic [15:0] bytes_seen;
  logic [15:0] bytes_seen_next;
  logic [15:0] bytes_seen_inc;
  logic [15:0] len;
  logic [1:0]  len_err;
  logic [15:0] head_pos;

  // Classify a completed length against the header size and the limit
  function automatic logic [1:0] check_length(input logic [15:0] l,
                                              input logic [15:0] hdr,
                                              input logic [15:0] lim);
    logic [1:0] e;
    begin
      e = ERR_NONE;
      if (l < hdr) begin
        e = ERR_TOO_SHORT;
      end else if (l > lim) begin
        e = ERR_TOO_LONG;
      end
      return e;
    end
  endfunction

  assign bytes_seen_inc = bytes_seen + 16'd1;
  assign head_pos       = two_byte_length ? (HDR_LONG - 16'd1) : (HDR_SHORT - 16'd1);
  assign len            = (phase == PH_LEN_SHORT) ? {8'h00, data_byte}
                                                  : {length_value[15:8], data_byte};
  assign len_err        = check_length(len, (phase == PH_LEN_SHORT) ? HDR_SHORT : HDR_LONG,
                                       max_frame_size);

  // Result and next state for the byte at the input
  always_comb begin
    result                = '0;
    result.byte_out       = data_byte;
    phase_next            = phase;
    two_byte_length_next  = two_byte_length;
    length_value_next     = length_value;
    bytes_seen_next       = bytes_seen;
    unique case (phase) inside
      PH_LEN_SHORT, PH_LEN_LOW: begin
        result.frame_length = len;
        result.error_code   = len_err;
        if (len_err != ERR_NONE) begin
          phase_next = PH_HUNT;
        end else begin
          result.in_frame   = 1'b1;
          length_value_next = len;
          bytes_seen_next   = (phase == PH_LEN_SHORT) ? 16'd2 : 16'd3;
          phase_next        = PH_BODY;
        end
      end
      PH_LEN_HIGH: begin
        length_value_next = {data_byte, 8'h00};
        bytes_seen_next   = 16'd2;
        result.in_frame   = 1'b1;
        phase_next        = PH_LEN_LOW;
      end
      PH_BODY: begin
        result.in_frame     = 1'b1;
        result.frame_length = length_value;
        result.is_head_code = (bytes_seen == head_pos);
        bytes_seen_next     = bytes_seen_inc;
        if (bytes_seen_inc >= length_value) begin
          result.last_of_frame = 1'b1;
          phase_next           = PH_HUNT;
        end
      end
      default: begin
        phase_next = PH_HUNT;
        if (data_byte == LEAD_SHORT || data_byte == LEAD_LONG) begin
          result.in_frame       = 1'b1;
          result.first_of_frame = 1'b1;
          two_byte_length_next  = (data_byte == LEAD_LONG);
          length_value_next     = '0;
          bytes_seen_next       = 16'd1;
          phase_next            = (data_byte == LEAD_LONG) ? PH_LEN_HIGH : PH_LEN_SHORT;
        end else begin
          result.error_code = ERR_LEAD;
        end
      end
    endcase
  end

  // Advance state on each transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_HUNT;
      two_byte_length <= 1'b0;
      length_value    <= '0;
      bytes_seen      <= '0;
    end else if (accept) begin
      phase           <= phase_next;
      two_byte_length <= two_byte_length_next;
      length_value    <= length_value_next;
      bytes_seen      <= bytes_seen_next;
    end
  end

  // Inside a frame body the count never reaches the length
  a_body_count: assert property (@(posedge clk) disable iff (rst)
    phase == PH_BODY |-> bytes_seen < length_value)
    else $error("body byte count reached frame length");

  // A delivered last byte sends the parser back to hunting
  a_last_hunts: assert property (@(posedge clk) disable iff (rst)
    accept && result.last_of_frame |=> phase == PH_HUNT)
    else $error("parser not hunting after last byte");

  // State moves only on a transfer
  a_hold: assert property (@(posedge clk) disable iff (rst)
    !accept |=> $stable(phase) && $stable(bytes_seen))
    else $error("parser state moved without a transfer");

endmodule

>>> design/lppd_out_stage.sv
// Output register with a skid entry, so the input side is decoupled from stalls.
// Depends on lppd_pkg for the result type.
`timescale 1ns / 1ps

module lppd_out_stage (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  lppd_pkg::lppd_result_t in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output lppd_pkg::lppd_result_t out_data
);
  import lppd_pkg::*;

  logic         skid_valid;
  lppd_result_t skid_data;
  logic         out_free;

  assign in_ready = !skid_valid;
  assign out_free = out_ready || !out_valid;

  // Valid flags
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_free) begin
      out_valid  <= skid_valid || in_valid;
      skid_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      skid_valid <= 1'b1;
    end
  end

  // Payload: refill output from skid first, else take the new transfer
  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_valid) begin
        out_data <= skid_data;
      end else if (in_valid) begin
        out_data <= in_data;
      end
    end else if (in_valid && in_ready) begin
      skid_data <= in_data;
    end
  end

  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry held with empty output register");

  a_skid_drains: assert property (@(posedge clk) disable iff (rst)
    skid_valid && out_ready |=> !skid_valid && out_valid)
    else $error("skid entry not moved to output");

  a_stall_fills: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready && in_valid && in_ready |=> skid_valid)
    else $error("transfer during stall not captured");

endmodule

>>> design/length_prefixed_packet_deframer.sv
// Top level of the length-prefixed packet deframer.
// Depends on lppd_pkg, lppd_parser and lppd_out_stage.
//
// Usage:
//   Bytes of the received stream enter on s_tvalid/s_tready/s_tdata, one per
//   transfer. A frame opens with lead byte 0xC1 (one-byte length) or 0xC2
//   (two-byte big-endian length); the length counts the whole frame.
//   Every input byte yields exactly one output transfer on the m_ channel:
//   the byte and the frame length in m_tdata, the end-of-frame mark in
//   m_tlast, and the in-frame, first, head-code and error marks in m_tuser.
//   Each result item is registered in the output stage before m_tvalid; one
//   byte per cycle is sustained while the receiver does not stall.
//   The cfg channel writes max_frame_size; it is always ready. The user is to
//   write it only while no bytes are in flight; the block does not enforce it.
//   Reset puts the parser in hunting, empties the output stage and loads
//   max_frame_size with MAX_FRAME.
//   When the receiver stalls, one more byte is taken into a skid entry, then
//   s_tready drops until the output register is taken.
`timescale 1ns / 1ps

module length_prefixed_packet_deframer #(
  parameter int MAX_FRAME = 4096
) (
  input  logic        clk,
  input  logic        rst,
  // Input bytes
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_byte
  // Result items
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // [7:0] byte_out, [23:8] frame_length
  output logic        m_tlast,   // last_of_frame
  output logic [4:0]  m_tuser,   // [0] in_frame, [1] first_of_frame, [2] is_head_code,
                                 // [4:3] error_code
  // Configuration write
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data   // max_frame_size
);
  import lppd_pkg::*;

  logic [15:0]  max_frame_size;
  logic         accept;
  lppd_result_t parse_result;
  lppd_result_t out_result;

  assign cfg_ready = 1'b1;
  assign accept    = s_tvalid && s_tready;

  // Hold the frame size limit
  always_ff @(posedge clk) begin
    if (rst) begin
      max_frame_size <= 16'(MAX_FRAME);
    end else if (cfg_valid && cfg_ready) begin
      max_frame_size <= cfg_data;
    end
  end

  lppd_parser u_parser (
    .clk            (clk),
    .rst            (rst),
    .accept         (accept),
    .data_byte      (s_tdata),
    .max_frame_size (max_frame_size),
    .result         (parse_result)
  );

  lppd_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_data   (parse_result),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (out_result)
  );

  // Pack result fields onto the stream ports
  assign m_tdata = {out_result.frame_length, out_result.byte_out};
  assign m_tlast = out_result.last_of_frame;
  assign m_tuser = {out_result.error_code, out_result.is_head_code,
                    out_result.first_of_frame, out_result.in_frame};

endmodule
